>>> sv/u8d_pkg.sv
// Shared types and constants for the UTF-8 byte stream decoder.
// No dependencies; imported by every module of the block.
package u8d_pkg;

    localparam int BYTE_W   = 8;
    localparam int CP_W     = 21;
    localparam int STATUS_W = 2;
    localparam int REM_W    = 2;
    localparam int OUT_TDATA_W = ((CP_W + 7) / 8) * 8;

    localparam logic [CP_W-1:0] REPLACEMENT_CP = CP_W'(63);

    typedef enum logic [STATUS_W-1:0] {
        ST_DECODED   = 2'd0,
        ST_MALFORMED = 2'd1,
        ST_INCOMPL   = 2'd2,
        ST_END       = 2'd3
    } status_t;

    typedef struct packed {
        logic [BYTE_W-1:0] byte_value;
        logic              end_of_input;
    } in_word_t;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        status_t         status;
    } out_word_t;

endpackage

>>> sv/u8d_in_reg.sv
// Input register of the UTF-8 decoder: takes one byte word per cycle unless stalled.
// Depends on u8d_pkg.
module u8d_in_reg
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  u8d_pkg::in_word_t in_word,
    output logic              held_valid,
    output u8d_pkg::in_word_t held_word,
    input  logic              advance
);
    import u8d_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_word_t word_reg;

    // Take a new word when the register is empty or the held one leaves in the same cycle.
    assign in_ready   = !valid_reg || advance;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            word_reg <= in_word;
        end
    end

    assign held_valid = valid_reg;
    assign held_word  = word_reg;

endmodule

>>> sv/u8d_core.sv
// Decode step of the UTF-8 decoder: sequence state and the per-byte logic.
// Depends on u8d_pkg.
module u8d_core
(
    input  logic               clk,
    input  logic               rst_n,
    input  u8d_pkg::in_word_t  word,
    input  logic               advance,
    output logic               emit,
    output u8d_pkg::out_word_t result
);
    import u8d_pkg::*;

    logic [REM_W-1:0]  rem_reg;
    logic [REM_W-1:0]  rem_next;
    logic [CP_W-1:0]   partial_reg;
    logic [CP_W-1:0]   partial_next;
    logic              bad_reg;
    logic              bad_next;

    logic [BYTE_W-1:0] b;
    logic              cont_bad;
    logic [CP_W-1:0]   shifted;
    logic [REM_W-1:0]  rem_dec;

    assign b        = word.byte_value;
    assign cont_bad = (b[7:6] != 2'b10);
    assign shifted  = {partial_reg[CP_W-7:0], b[5:0]};
    assign rem_dec  = rem_reg - REM_W'(1);

    always_comb
    begin
        rem_next          = rem_reg;
        partial_next      = partial_reg;
        bad_next          = bad_reg;
        emit              = 1'b0;
        result.code_point = '0;
        result.status     = ST_DECODED;

        if (word.end_of_input)
        begin
            emit          = 1'b1;
            result.status = (rem_reg != '0) ? ST_INCOMPL : ST_END;
            rem_next      = '0;
            partial_next  = '0;
            bad_next      = 1'b0;
        end
        else if (rem_reg == '0)
        begin
            if (b[7] == 1'b0)
            begin
                emit              = 1'b1;
                result.code_point = CP_W'(b);
            end
            else if (b[7:5] == 3'b110)
            begin
                rem_next     = REM_W'(1);
                partial_next = CP_W'(b[4:0]);
                bad_next     = 1'b0;
            end
            else if (b[7:4] == 4'b1110)
            begin
                rem_next     = REM_W'(2);
                partial_next = CP_W'(b[3:0]);
                bad_next     = 1'b0;
            end
            else if (b[7:3] == 5'b11110)
            begin
                rem_next     = REM_W'(3);
                partial_next = CP_W'(b[2:0]);
                bad_next     = 1'b0;
            end
            else
            begin
                // stray continuation or invalid lead byte
                emit              = 1'b1;
                result.code_point = REPLACEMENT_CP;
                result.status     = ST_MALFORMED;
            end
        end
        else
        begin
            // consume as continuation whatever its value
            rem_next     = rem_dec;
            partial_next = shifted;
            bad_next     = bad_reg | cont_bad;
            if (rem_dec == '0)
            begin
                emit         = 1'b1;
                partial_next = '0;
                bad_next     = 1'b0;
                if (bad_reg || cont_bad)
                begin
                    result.code_point = REPLACEMENT_CP;
                    result.status     = ST_MALFORMED;
                end
                else
                begin
                    result.code_point = shifted;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg     <= '0;
            partial_reg <= '0;
            bad_reg     <= 1'b0;
        end
        else if (advance)
        begin
            rem_reg     <= rem_next;
            partial_reg <= partial_next;
            bad_reg     <= bad_next;
        end
    end

endmodule

>>> sv/u8d_out_reg.sv
// Result register of the UTF-8 decoder: holds one decoded word for the sink.
// Depends on u8d_pkg.
module u8d_out_reg
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  u8d_pkg::out_word_t load_word,
    output logic               can_load,
    output logic               out_valid,
    input  logic               out_ready,
    output u8d_pkg::out_word_t out_word
);
    import u8d_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    out_word_t word_reg;

    // Refill when empty or in the cycle the sink takes the current word.
    assign can_load   = !valid_reg || out_ready;
    assign valid_next = load ? 1'b1 : (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg <= load_word;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

>>> sv/utf8_byte_stream_decoder.sv
// UTF-8 byte stream decoder, top level.
// Depends on u8d_pkg, u8d_in_reg, u8d_core and u8d_out_reg.
//
// Takes one byte word per cycle, or an end marker (s_tuser high), and returns
// code points of up to 21 bits. Throughput is one word every cycle unless a
// result is held up by a stalled sink; a word passes the input register and
// then the result register. Lead and middle bytes of a sequence give no
// result. A bad continuation or a stray byte gives '?' with malformed
// status; an end marker gives incomplete or clean end status.
module utf8_byte_stream_decoder
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [u8d_pkg::BYTE_W-1:0]          s_tdata,  // byte_value
    input  logic                                s_tuser,  // end_of_input
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [u8d_pkg::OUT_TDATA_W-1:0]     m_tdata,  // code_point, zero pad
    output logic [u8d_pkg::STATUS_W-1:0]        m_tuser   // status
);
    import u8d_pkg::*;

    in_word_t  s_word;
    in_word_t  held_word;
    logic      held_valid;
    logic      advance;
    logic      emit;
    out_word_t result;
    logic      can_load;
    out_word_t out_word;

    assign s_word.byte_value   = s_tdata;
    assign s_word.end_of_input = s_tuser;

    // Advance the held word when its result, if any, has room.
    assign advance = held_valid && (!emit || can_load);

    u8d_in_reg u_in_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_word    (s_word),
        .held_valid (held_valid),
        .held_word  (held_word),
        .advance    (advance)
    );

    u8d_core u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .word    (held_word),
        .advance (advance),
        .emit    (emit),
        .result  (result)
    );

    u8d_out_reg u_out_reg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance && emit),
        .load_word (result),
        .can_load  (can_load),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_word  (out_word)
    );

    assign m_tdata = OUT_TDATA_W'(out_word.code_point);
    assign m_tuser = out_word.status;

endmodule

>>> tb/tb_utf8_byte_stream_decoder.sv
// Testbench for utf8_byte_stream_decoder: directed and random byte streams,
// checked word by word against a behavioral UTF-8 decoder.
// Depends on u8d_pkg and the RTL of the block.
`timescale 1ns / 100ps

module tb_utf8_byte_stream_decoder;

    import u8d_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;

    typedef enum int {
        STALL_NONE,
        STALL_RANDOM,
        STALL_PERIODIC
    } stall_mode_t;

    typedef struct {
        logic [CP_W-1:0] cp;
        status_t         st;
    } decoded_t;

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [BYTE_W-1:0]      s_tdata  = '0;
    logic                   s_tuser  = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]    m_tuser;

    // decoder state mirrored by the predictor
    logic [REM_W-1:0] pend_cnt  = '0;
    logic [CP_W-1:0]  acc_cp    = '0;
    logic             cont_bad  = 1'b0;

    decoded_t    decoded_q[$];
    int          fail_count  = 0;
    int          cycle_count = 0;
    int          gap_max     = 0;
    int          burst_left  = 0;
    stall_mode_t stall_mode  = STALL_NONE;
    int unsigned ready_phase = 0;

    utf8_byte_stream_decoder dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // receiver stall pattern
    always @(posedge clk)
    begin
        ready_phase <= ready_phase + 1;
        case (stall_mode)
            STALL_NONE:     m_tready <= 1'b1;
            STALL_RANDOM:   m_tready <= ($urandom_range(0, 3) != 0);
            STALL_PERIODIC: m_tready <= ((ready_phase % 11) < 6);
            default:        m_tready <= 1'b1;
        endcase
    end

    // Advance the decoder by one accepted word; returns 1 when a result is due.
    function automatic bit predict_decode(input logic [BYTE_W-1:0] b, input bit eoi,
                                          output decoded_t res);
        res.cp = '0;
        res.st = ST_DECODED;
        if (eoi)
        begin
            res.st   = (pend_cnt != 0) ? ST_INCOMPL : ST_END;
            pend_cnt = '0;
            acc_cp   = '0;
            cont_bad = 1'b0;
            return 1'b1;
        end
        if (pend_cnt == 0)
        begin
            if (b[7] == 1'b0)
            begin
                res.cp = CP_W'(b);
                return 1'b1;
            end
            else if (b[7:5] == 3'b110)
            begin
                pend_cnt = 2'd1;
                acc_cp   = CP_W'(b[4:0]);
            end
            else if (b[7:4] == 4'b1110)
            begin
                pend_cnt = 2'd2;
                acc_cp   = CP_W'(b[3:0]);
            end
            else if (b[7:3] == 5'b11110)
            begin
                pend_cnt = 2'd3;
                acc_cp   = CP_W'(b[2:0]);
            end
            else
            begin
                // stray continuation or invalid lead
                res.cp = REPLACEMENT_CP;
                res.st = ST_MALFORMED;
                return 1'b1;
            end
            cont_bad = 1'b0;
            return 1'b0;
        end
        // consume as continuation whatever the byte looks like
        if (b[7:6] != 2'b10)
            cont_bad = 1'b1;
        acc_cp   = {acc_cp[CP_W-7:0], b[5:0]};
        pend_cnt = pend_cnt - 2'd1;
        if (pend_cnt != 0)
            return 1'b0;
        if (cont_bad)
        begin
            res.cp = REPLACEMENT_CP;
            res.st = ST_MALFORMED;
        end
        else
            res.cp = acc_cp;
        acc_cp   = '0;
        cont_bad = 1'b0;
        return 1'b1;
    endfunction

    always @(posedge clk)
    begin
        decoded_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (decoded_q.size() == 0)
            begin
                $error("unexpected result: code_point %0h status %0d",
                       m_tdata[CP_W-1:0], m_tuser);
                fail_count++;
            end
            else
            begin
                want = decoded_q.pop_front();
                if (m_tdata[CP_W-1:0] !== want.cp)
                begin
                    $error("code_point mismatch: expected %0h, actual %0h",
                           want.cp, m_tdata[CP_W-1:0]);
                    fail_count++;
                end
                if (m_tdata[OUT_TDATA_W-1:CP_W] !== '0)
                begin
                    $error("tdata pad mismatch: expected 0, actual %0h",
                           m_tdata[OUT_TDATA_W-1:CP_W]);
                    fail_count++;
                end
                if (m_tuser !== want.st)
                begin
                    $error("status mismatch: expected %0d, actual %0d", want.st, m_tuser);
                    fail_count++;
                end
            end
        end
    end

    // Send one word, with burst/gap idling, and record its result if any.
    task automatic send_word(input logic [BYTE_W-1:0] b, input bit eoi);
        decoded_t res;
        if (burst_left == 0)
        begin
            if (gap_max != 0)
            begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, gap_max)) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= eoi;
        do
            @(posedge clk);
        while (!s_tready);
        if (predict_decode(b, eoi, res))
            decoded_q.push_back(res);
    endtask

    // Drop valid and hold until every expected word is back.
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (decoded_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [BYTE_W-1:0] rand_cont();
        return 8'h80 | BYTE_W'($urandom_range(0, 63));
    endfunction

    function automatic logic [BYTE_W-1:0] rand_bad_cont();
        logic [BYTE_W-1:0] b;
        b = BYTE_W'($urandom_range(0, 255));
        if (b[7:6] == 2'b10)
            b = b ^ 8'h40;
        return b;
    endfunction

    function automatic logic [BYTE_W-1:0] rand_lead(input int len);
        case (len)
            1:       return BYTE_W'($urandom_range(0, 127));
            2:       return 8'hC0 | BYTE_W'($urandom_range(0, 31));
            3:       return 8'hE0 | BYTE_W'($urandom_range(0, 15));
            default: return 8'hF0 | BYTE_W'($urandom_range(0, 7));
        endcase
    endfunction

    // Send one random sequence, mostly well formed; returns words sent.
    task automatic send_random_sequence(output int sent);
        int kind;
        int len;
        int bad_pos;
        int cut;
        kind = $urandom_range(0, 99);
        sent = 0;
        if (kind < 55)
        begin
            len = $urandom_range(1, 4);
            send_word(rand_lead(len), 1'b0);
            for (int i = 1; i < len; i++)
                send_word(rand_cont(), 1'b0);
            sent = len;
        end
        else if (kind < 65)
        begin
            len     = $urandom_range(2, 4);
            bad_pos = $urandom_range(1, len - 1);
            send_word(rand_lead(len), 1'b0);
            for (int i = 1; i < len; i++)
                send_word((i == bad_pos) ? rand_bad_cont() : rand_cont(), 1'b0);
            sent = len;
        end
        else if (kind < 72)
        begin
            // truncated sequence closed by an end marker
            len = $urandom_range(2, 4);
            cut = $urandom_range(0, len - 2);
            send_word(rand_lead(len), 1'b0);
            for (int i = 0; i < cut; i++)
                send_word(($urandom_range(0, 4) == 0) ? rand_bad_cont() : rand_cont(), 1'b0);
            send_word(BYTE_W'($urandom_range(0, 255)), 1'b1);
            sent = cut + 2;
        end
        else if (kind < 80)
        begin
            if ($urandom_range(0, 1) == 0)
                send_word(rand_cont(), 1'b0);
            else
                send_word(8'hF8 | BYTE_W'($urandom_range(0, 7)), 1'b0);
            sent = 1;
        end
        else if (kind < 88)
        begin
            send_word(BYTE_W'($urandom_range(0, 255)), 1'b1);
            sent = 1;
        end
        else
        begin
            send_word(BYTE_W'($urandom_range(0, 255)), 1'b0);
            sent = 1;
        end
    endtask

    task automatic run_random_stream(input int n_words, input int gaps, input stall_mode_t sm);
        int total;
        int sent;
        total      = 0;
        gap_max    = gaps;
        stall_mode = sm;
        burst_left = 0;
        while (total < n_words)
        begin
            send_random_sequence(sent);
            total += sent;
        end
        // close any open sequence so the next phase starts clean
        send_word(8'h00, 1'b1);
        wait_for_results();
    endtask

    task automatic test_directed_cases();
        logic [BYTE_W-1:0] seq[$];
        gap_max    = 0;
        stall_mode = STALL_NONE;
        seq = '{8'h00, 8'h7F,                     // ASCII extremes
                8'hDF, 8'hBF,                     // two-byte max
                8'hEF, 8'hBF, 8'hBF,              // three-byte max
                8'hF7, 8'hBF, 8'hBF, 8'hBF,       // four-byte, largest code point
                8'h80,                            // stray continuation
                8'hFF, 8'hF8,                     // invalid leads
                8'hC3, 8'hC3,                     // lead-like byte eaten as continuation
                8'hE2, 8'h41, 8'h82};             // bad continuation mid-sequence
        foreach (seq[i])
            send_word(seq[i], 1'b0);
        // end inside a sequence, then inside one with a bad continuation
        send_word(8'hF0, 1'b0);
        send_word(8'h00, 1'b1);
        send_word(8'hE2, 1'b0);
        send_word(8'h41, 1'b0);
        send_word(8'hFF, 1'b1);
        // clean ends, repeated
        send_word(8'hA5, 1'b1);
        send_word(8'h00, 1'b1);
        wait_for_results();
    endtask

    task automatic test_back_to_back_stream();
        run_random_stream(106, 0, STALL_NONE);
    endtask

    task automatic test_bursty_sender();
        run_random_stream(106, 6, STALL_NONE);
    endtask

    task automatic test_receiver_backpressure();
        run_random_stream(106, 0, STALL_PERIODIC);
    endtask

    task automatic test_mixed_idling();
        run_random_stream(106, 4, STALL_RANDOM);
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_directed_cases();
        test_back_to_back_stream();
        test_bursty_sender();
        test_receiver_backpressure();
        test_mixed_idling();

        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
